>>> hw/rtl/bsee_pkg.sv
// Shared types for the early-exit bubble sort core.
// Holds the controller state encoding and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package bsee_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_FETCH,
        S_CMP,
        S_END,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic pass_start;
        logic fetch;
        logic compare;
        logic pass_end;
        logic set_early;
        logic out_init;
        logic out_rd;
        logic out_last;
        logic clr_count;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic idx_at_lim;
        logic lim_one;
        logic swapped;
        logic out_at_end;
    } sts_t;

endpackage

>>> hw/rtl/bsee_dpath.sv
// Datapath of the early-exit bubble sort core: element memory, counters,
// bubble carry register, comparator and result registers.
// Depends on bsee_pkg.
`timescale 1ns / 1ps

module bsee_dpath
    import bsee_pkg::*;
#(
    parameter int MAX_COUNT = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic signed [DATA_W-1:0] value_in,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] value_out,
    output logic                     early_exit,
    output logic                     last_out
);

    localparam int AW = $clog2(MAX_COUNT);
    localparam int CW = $clog2(MAX_COUNT + 1);

    logic [DATA_W-1:0] mem [MAX_COUNT];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] carry_reg, carry_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     lim_reg, lim_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              swap_reg, swap_next;
    logic              early_reg, early_next;
    logic              valid_reg, last_reg;

    logic [AW-1:0]     slot;
    logic              gt;
    logic              we;
    logic [AW-1:0]     wa;
    logic [DATA_W-1:0] wd;
    logic              re;
    logic [AW-1:0]     ra;

    assign slot = (count_reg < CW'(MAX_COUNT)) ? count_reg[AW-1:0] : AW'(MAX_COUNT - 1);
    assign gt   = $signed(carry_reg) > $signed(rd_data_reg);

    always_comb
    begin
        we         = 1'b0;
        wa         = slot;
        wd         = value_in;
        re         = 1'b0;
        ra         = idx_reg;
        carry_next = carry_reg;
        count_next = count_reg;
        lim_next   = lim_reg;
        idx_next   = idx_reg;
        swap_next  = swap_reg;
        early_next = early_reg;

        if (cmd.load)
        begin
            we = 1'b1;
            if (count_reg < CW'(MAX_COUNT))
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.sort_init)
        begin
            lim_next   = slot;
            early_next = 1'b0;
        end
        if (cmd.pass_start)
        begin
            re        = 1'b1;
            ra        = '0;
            idx_next  = AW'(1);
            swap_next = 1'b0;
        end
        if (cmd.fetch)
        begin
            re         = 1'b1;
            ra         = idx_reg;
            carry_next = rd_data_reg;
        end
        if (cmd.compare)
        begin
            we       = 1'b1;
            wa       = idx_reg - AW'(1);
            re       = 1'b1;
            ra       = idx_reg + AW'(1);
            idx_next = idx_reg + AW'(1);
            if (gt)
            begin
                wd        = rd_data_reg;
                swap_next = 1'b1;
            end
            else
            begin
                wd         = carry_reg;
                carry_next = rd_data_reg;
            end
        end
        if (cmd.pass_end)
        begin
            we       = 1'b1;
            wa       = lim_reg;
            wd       = carry_reg;
            lim_next = lim_reg - AW'(1);
        end
        if (cmd.set_early)
        begin
            early_next = 1'b1;
        end
        if (cmd.out_init)
        begin
            idx_next = '0;
        end
        if (cmd.out_rd)
        begin
            re       = 1'b1;
            ra       = idx_reg;
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        lim_reg   <= lim_next;
        idx_reg   <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            swap_reg  <= 1'b0;
            early_reg <= 1'b0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            swap_reg  <= swap_next;
            early_reg <= early_next;
            valid_reg <= cmd.out_rd;
            last_reg  <= cmd.out_rd & cmd.out_last;
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.idx_at_lim = (idx_reg == lim_reg);
    assign sts.lim_one    = (lim_reg == AW'(1));
    assign sts.swapped    = swap_reg;
    assign sts.out_at_end = (CW'(idx_reg) + CW'(1) == count_reg);

    assign result_valid = valid_reg;
    assign value_out    = $signed(rd_data_reg);
    assign early_exit   = early_reg;
    assign last_out     = last_reg;

endmodule

>>> hw/rtl/bsee_ctrl.sv
// Controller of the early-exit bubble sort core: load, sort passes, readout.
// Depends on bsee_pkg.
`timescale 1ns / 1ps

module bsee_ctrl
    import bsee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic last_in,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_in)
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_early = 1'b1;
                            cmd.out_init  = 1'b1;
                            state_next    = S_OUT;
                        end
                        else
                        begin
                            cmd.sort_init = 1'b1;
                            state_next    = S_PASS;
                        end
                    end
                end
            end
            S_PASS:
            begin
                cmd.pass_start = 1'b1;
                state_next     = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                if (sts.idx_at_lim)
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                cmd.pass_end = 1'b1;
                if (!sts.swapped)
                begin
                    cmd.set_early = 1'b1;
                    cmd.out_init  = 1'b1;
                    state_next    = S_OUT;
                end
                else if (sts.lim_one)
                begin
                    cmd.out_init = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_PASS;
                end
            end
            S_OUT:
            begin
                cmd.out_rd   = 1'b1;
                cmd.out_last = sts.out_at_end;
                if (sts.out_at_end)
                begin
                    cmd.clr_count = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/bubble_sort_early_exit_core.sv
// Bubble sort with early exit: collects a set of signed words, sorts them
// ascending, streams them out. Top level; depends on bsee_pkg, bsee_ctrl,
// bsee_dpath.
//
// Input: a transfer happens when start is high and busy is low. Each transfer
// stores value_in in the next slot. Once MAX_COUNT values are held, further
// values overwrite the last slot. last_in marks the final value and starts
// the sort; busy stays high until the set has been streamed out.
// Sort: one comparator and a single-port-write memory. Each pass runs over a
// prefix one entry shorter than the last; passes stop after the first pass
// without a swap, or after the pass over the first two entries.
// Output: result_valid pulses for one cycle per value, smallest first, on
// consecutive cycles; last_out marks the final one; early_exit is the same for
// the whole set. Results are shown from registered memory reads. A set of
// one value goes straight to output with early_exit high.
// The receiver cannot stall: every result must be taken when shown.
// Reset (rst_n low, asynchronous) empties the set and returns to idle.
`timescale 1ns / 1ps

module bubble_sort_early_exit_core
    import bsee_pkg::*;
#(
    parameter int MAX_COUNT = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value_in,
    input  logic                     last_in,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] value_out,
    output logic                     early_exit,
    output logic                     last_out
);

    cmd_t cmd;
    sts_t sts;

    bsee_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .last_in (last_in),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    bsee_dpath #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .value_in     (value_in),
        .result_valid (result_valid),
        .value_out    (value_out),
        .early_exit   (early_exit),
        .last_out     (last_out)
    );

`ifndef SYNTHESIS
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a preceding busy cycle");

    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_out |-> !busy)
        else $error("core still busy on final result");

    a_last_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_in |=> busy)
        else $error("final value did not start sorting");

    a_early_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_out |=> result_valid && $stable(early_exit))
        else $error("result stream broken or early_exit changed within a set");
`endif

endmodule
